[hw/rtl/tclp_pkg.sv]
package tclp_pkg;

    typedef enum logic [4:0] {
        PH_START,
        PH_S,
        PH_SE,
        PH_SY,
        PH_SYN,
        PH_SYNC_OK,
        PH_FAIL,
        PH_SET_OK,
        PH_N0_SKIP,
        PH_N0_SIGN,
        PH_N0_DIG,
        PH_N1_SKIP,
        PH_N1_SIGN,
        PH_N1_DIG,
        PH_N2_SKIP,
        PH_N2_SIGN,
        PH_N2_DIG
    } phase_t;

    typedef enum logic [1:0] {
        SUB_SKIP = 2'd0,
        SUB_SIGN = 2'd1,
        SUB_DIG  = 2'd2
    } sub_t;

    typedef enum logic [1:0] {
        CMD_NO_OP   = 2'd0,
        CMD_SET     = 2'd1,
        CMD_RESYNC  = 2'd2
    } cmd_t;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_VT    = 8'd11;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_C     = 8'd67;
    localparam logic [7:0] CHAR_E     = 8'd69;
    localparam logic [7:0] CHAR_N     = 8'd78;
    localparam logic [7:0] CHAR_S     = 8'd83;
    localparam logic [7:0] CHAR_T     = 8'd84;
    localparam logic [7:0] CHAR_Y     = 8'd89;

    localparam int unsigned NUM_COUNT = 3;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_SPACE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // acc * 10 +/- digit, modulo 256
    function automatic logic [7:0] digit_step(input logic [7:0] acc, input logic [7:0] c,
                                              input logic neg);
        logic [7:0] d;
        logic [7:0] v;
        d = c - CHAR_ZERO;
        v = (acc << 3) + (acc << 1);
        return neg ? (v - d) : (v + d);
    endfunction

    function automatic phase_t num_phase(input logic [1:0] k, input sub_t sub);
        phase_t p;
        unique case ({k, sub})
            {2'd0, SUB_SKIP}: p = PH_N0_SKIP;
            {2'd0, SUB_SIGN}: p = PH_N0_SIGN;
            {2'd0, SUB_DIG}:  p = PH_N0_DIG;
            {2'd1, SUB_SKIP}: p = PH_N1_SKIP;
            {2'd1, SUB_SIGN}: p = PH_N1_SIGN;
            {2'd1, SUB_DIG}:  p = PH_N1_DIG;
            {2'd2, SUB_SKIP}: p = PH_N2_SKIP;
            {2'd2, SUB_SIGN}: p = PH_N2_SIGN;
            {2'd2, SUB_DIG}:  p = PH_N2_DIG;
            default:          p = PH_FAIL;
        endcase
        return p;
    endfunction

endpackage

[hw/rtl/text_command_line_parser_core.sv]
// A newline passes the input register and then the result register (m_tvalid).
// Throughput: one byte per cycle; the input register and the result register
// let a byte be taken while a result waits, and only a newline that finds the
// result register full and stalled holds the input side.
// Reset (rst_n low, asynchronous): no request pending, parser at start of line,
// line empty.
module text_command_line_parser_core
    import tclp_pkg::*;
#(
    parameter int LINE_MAX = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] command, [9:2] hour, [17:10] minute,
                                   // [25:18] second, [31:26] zero
);

    localparam int LEN_W = $clog2(LINE_MAX);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_MAX - 1);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    cmd_t             out_cmd_reg;
    logic [7:0]       out_hour_reg;
    logic [7:0]       out_minute_reg;
    logic [7:0]       out_second_reg;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             neg_reg;
    logic             neg_next;
    logic [7:0]       acc_reg  [NUM_COUNT];
    logic [7:0]       acc_next [NUM_COUNT];

    logic             is_lf;
    logic             advance;
    logic             emit;
    cmd_t             cmd;

    logic [1:0]       k_cur;
    sub_t             sub_cur;
    logic [1:0]       k_eff;
    sub_t             sub_eff;
    logic             in_num;
    logic [7:0]       c;

    assign c       = in_byte_reg;
    assign is_lf   = (c == CHAR_LF);
    assign advance = in_valid_reg && !(is_lf && out_valid_reg && !m_tready);
    assign emit    = advance && is_lf;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_second_reg, out_minute_reg, out_hour_reg, out_cmd_reg};

    always_comb
    begin
        if (phase_reg == PH_SYNC_OK)
            cmd = CMD_RESYNC;
        else if (phase_reg == PH_SET_OK || phase_reg == PH_N2_DIG)
            cmd = CMD_SET;
        else
            cmd = CMD_NO_OP;
    end

    // decode number index and sub-phase
    always_comb
    begin
        in_num  = 1'b1;
        k_cur   = 2'd0;
        sub_cur = SUB_SKIP;
        unique case (phase_reg)
            PH_N0_SKIP: begin k_cur = 2'd0; sub_cur = SUB_SKIP; end
            PH_N0_SIGN: begin k_cur = 2'd0; sub_cur = SUB_SIGN; end
            PH_N0_DIG:  begin k_cur = 2'd0; sub_cur = SUB_DIG;  end
            PH_N1_SKIP: begin k_cur = 2'd1; sub_cur = SUB_SKIP; end
            PH_N1_SIGN: begin k_cur = 2'd1; sub_cur = SUB_SIGN; end
            PH_N1_DIG:  begin k_cur = 2'd1; sub_cur = SUB_DIG;  end
            PH_N2_SKIP: begin k_cur = 2'd2; sub_cur = SUB_SKIP; end
            PH_N2_SIGN: begin k_cur = 2'd2; sub_cur = SUB_SIGN; end
            PH_N2_DIG:  begin k_cur = 2'd2; sub_cur = SUB_DIG;  end
            default:    in_num = 1'b0;
        endcase
    end

    // a non-digit after the first or second number is taken again by the next one
    always_comb
    begin
        k_eff   = k_cur;
        sub_eff = sub_cur;
        if (sub_cur == SUB_DIG && !is_digit(c) && k_cur != 2'd2)
        begin
            k_eff   = k_cur + 2'd1;
            sub_eff = SUB_SKIP;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        neg_next   = neg_reg;
        for (int i = 0; i < NUM_COUNT; i++)
        begin
            acc_next[i] = acc_reg[i];
        end

        if (!advance || c == CHAR_CR)
        begin
            // hold
        end
        else if (is_lf || len_reg >= LEN_LAST)
        begin
            phase_next = PH_START;
            len_next   = '0;
            neg_next   = 1'b0;
            for (int i = 0; i < NUM_COUNT; i++)
            begin
                acc_next[i] = 8'd0;
            end
        end
        else
        begin
            len_next = len_reg + LEN_W'(1);
            if (c == CHAR_NUL)
            begin
                if (phase_reg == PH_N2_DIG)
                    phase_next = PH_SET_OK;
                else if (phase_reg != PH_SYNC_OK && phase_reg != PH_SET_OK)
                    phase_next = PH_FAIL;
            end
            else if (!in_num)
            begin
                unique case (phase_reg)
                    PH_START: phase_next = (c == CHAR_S) ? PH_S : PH_FAIL;
                    PH_S:     phase_next = (c == CHAR_E) ? PH_SE :
                                           (c == CHAR_Y) ? PH_SY : PH_FAIL;
                    PH_SE:    phase_next = (c == CHAR_T) ? PH_N0_SKIP : PH_FAIL;
                    PH_SY:    phase_next = (c == CHAR_N) ? PH_SYN : PH_FAIL;
                    PH_SYN:   phase_next = (c == CHAR_C) ? PH_SYNC_OK : PH_FAIL;
                    default:  phase_next = phase_reg;
                endcase
            end
            else if (sub_cur == SUB_DIG && !is_digit(c) && k_cur == 2'd2)
            begin
                phase_next = PH_SET_OK;
            end
            else
            begin
                unique case (sub_eff)
                    SUB_SKIP:
                    begin
                        if (is_blank(c))
                            phase_next = num_phase(k_eff, SUB_SKIP);
                        else if (c == CHAR_PLUS || c == CHAR_MINUS)
                        begin
                            neg_next        = (c == CHAR_MINUS);
                            acc_next[k_eff] = 8'd0;
                            phase_next      = num_phase(k_eff, SUB_SIGN);
                        end
                        else if (is_digit(c))
                        begin
                            neg_next        = 1'b0;
                            acc_next[k_eff] = digit_step(8'd0, c, 1'b0);
                            phase_next      = num_phase(k_eff, SUB_DIG);
                        end
                        else
                            phase_next = PH_FAIL;
                    end
                    SUB_SIGN:
                    begin
                        if (is_digit(c))
                        begin
                            acc_next[k_eff] = digit_step(acc_reg[k_eff], c, neg_reg);
                            phase_next      = num_phase(k_eff, SUB_DIG);
                        end
                        else
                            phase_next = PH_FAIL;
                    end
                    SUB_DIG:
                    begin
                        acc_next[k_eff] = digit_step(acc_reg[k_eff], c, neg_reg);
                    end
                    default: phase_next = PH_FAIL;
                endcase
            end
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            len_reg       <= '0;
            neg_reg       <= 1'b0;
            for (int i = 0; i < NUM_COUNT; i++)
            begin
                acc_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            neg_reg       <= neg_next;
            for (int i = 0; i < NUM_COUNT; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (emit)
        begin
            out_cmd_reg    <= cmd;
            out_hour_reg   <= (cmd == CMD_SET) ? acc_reg[0] : 8'd0;
            out_minute_reg <= (cmd == CMD_SET) ? acc_reg[1] : 8'd0;
            out_second_reg <= (cmd == CMD_SET) ? acc_reg[2] : 8'd0;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_LAST)
        else $error("line length beyond limit");

    a_result_from_lf: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_valid_reg && in_byte_reg == CHAR_LF))
        else $error("result without newline");

    a_lf_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_START && len_reg == '0))
        else $error("line not cleared after newline");

    a_cmd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_cmd_reg == CMD_NO_OP || out_cmd_reg == CMD_SET
                      || out_cmd_reg == CMD_RESYNC))
        else $error("bad command code");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_cmd_reg != CMD_SET) |->
            (out_hour_reg == 8'd0 && out_minute_reg == 8'd0 && out_second_reg == 8'd0))
        else $error("time fields set without set command");

endmodule
